### sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, character constants and lookup helpers for the source text
// tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int POS_BITS   = 32;
   localparam int LEN_BITS   = 32;
   localparam int KIND_BITS  = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_B     = 8'h62;

   localparam logic [KIND_BITS-1:0] KIND_STRING = 5'd21;
   localparam logic [KIND_BITS-1:0] KIND_SPACES = 5'd22;
   localparam logic [KIND_BITS-1:0] KIND_TABS   = 5'd23;
   localparam logic [KIND_BITS-1:0] KIND_WORD   = 5'd24;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER = 5'd25;

   localparam int NUM_SINGLES = 21;

   // one-byte tokens; the kind code is the position in this list
   localparam logic [7:0] SINGLE_CHARS [NUM_SINGLES] = '{
      8'h2B, 8'h2D, 8'h2A, 8'h3D, 8'h26, 8'h2F, 8'h21, 8'h25, 8'h5E, 8'h28, 8'h29,
      8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3C, 8'h3E, 8'h0A, 8'h3B, 8'h2C, 8'h27
   };

   typedef enum logic [2:0] {
      MODE_NONE   = 3'd0,
      MODE_STRING = 3'd1,
      MODE_SPACES = 3'd2,
      MODE_TABS   = 3'd3,
      MODE_WORD   = 3'd4,
      MODE_NUMBER = 3'd5,
      MODE_ZERO   = 3'd6
   } stt_mode_type;

   typedef struct packed {
      stt_mode_type          mode;
      logic [POS_BITS-1:0]   start;
      logic [LEN_BITS-1:0]   length;
      logic [POS_BITS-1:0]   pos;
   } stt_state_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [31:0]           start;
      logic [31:0]           length;
      logic                  open_string;
      logic                  final_token;
   } stt_result_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   // {hit, kind} for one-byte tokens
   function automatic logic [KIND_BITS:0] single_kind(input logic [7:0] c);
      logic [KIND_BITS:0] r;
      r = '0;
      for (int i = 0; i < NUM_SINGLES; i++) begin
         if (SINGLE_CHARS[i] == c) begin
            r = {1'b1, KIND_BITS'(i)};
         end
      end
      return r;
   endfunction

   function automatic logic extends_run(input stt_mode_type m, input logic [7:0] c);
      logic r;
      case (m)
         MODE_STRING: r = 1'b1;
         MODE_SPACES: r = (c == CHAR_SPACE);
         MODE_TABS:   r = (c == CHAR_TAB);
         MODE_WORD:   r = is_letter(c);
         MODE_NUMBER: r = is_digit(c);
         MODE_ZERO:   r = is_digit(c) || c == CHAR_X || c == CHAR_B;
         default:     r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [KIND_BITS-1:0] mode_kind(input stt_mode_type m);
      logic [KIND_BITS-1:0] k;
      case (m)
         MODE_STRING: k = KIND_STRING;
         MODE_SPACES: k = KIND_SPACES;
         MODE_TABS:   k = KIND_TABS;
         MODE_WORD:   k = KIND_WORD;
         default:     k = KIND_NUMBER;
      endcase
      return k;
   endfunction

endpackage

### sv/stt_step.sv
// ----------------------------------------------------------------------------
// stt_step
// Per-byte lexer step: from the pending token state and one byte, forms the
// next state and up to two tokens.
// ----------------------------------------------------------------------------
module stt_step
   import stt_pkg::*;
(
   input  stt_state_type   cur,
   input  logic [7:0]      char_byte,
   input  logic            source_end,
   output stt_state_type   nxt,
   output stt_result_type  res [2],
   output logic [1:0]      res_count
);

   always_comb begin
      logic                  ext;
      logic [KIND_BITS:0]    sk;
      logic [LEN_BITS-1:0]   len_inc;
      stt_mode_type          m;

      ext     = (cur.mode != MODE_NONE) && extends_run(cur.mode, char_byte);
      sk      = single_kind(char_byte);
      len_inc = (cur.length == '1) ? cur.length : cur.length + LEN_BITS'(1);
      m       = MODE_NONE;

      nxt       = cur;
      nxt.pos   = POS_BITS'(cur.pos + POS_BITS'(1));
      res[0]    = '0;
      res[1]    = '0;
      res_count = 2'd0;

      if (ext) begin
         nxt.length = len_inc;
         if (cur.mode == MODE_ZERO) begin
            nxt.mode = MODE_NUMBER;
         end
         if (cur.mode == MODE_STRING && char_byte == CHAR_QUOTE) begin
            res[0]    = '{KIND_STRING, 32'(cur.start), 32'(len_inc), 1'b0, 1'b0};
            res_count = 2'd1;
            nxt.mode  = MODE_NONE;
         end
      end else begin
         if (cur.mode != MODE_NONE) begin
            res[0]    = '{mode_kind(cur.mode), 32'(cur.start), 32'(cur.length),
                          1'b0, 1'b0};
            res_count = 2'd1;
            nxt.mode  = MODE_NONE;
         end
         if (sk[KIND_BITS]) begin
            res[res_count[0]] = '{sk[KIND_BITS-1:0], 32'(cur.pos), 32'd1, 1'b0, 1'b0};
            res_count         = res_count + 2'd1;
         end else begin
            if (char_byte == CHAR_QUOTE) m = MODE_STRING;
            else if (char_byte == CHAR_SPACE) m = MODE_SPACES;
            else if (char_byte == CHAR_TAB) m = MODE_TABS;
            else if (is_letter(char_byte)) m = MODE_WORD;
            else if (char_byte == CHAR_ZERO) m = MODE_ZERO;
            else if (is_digit(char_byte)) m = MODE_NUMBER;
            if (m != MODE_NONE) begin
               nxt.mode   = m;
               nxt.start  = cur.pos;
               nxt.length = LEN_BITS'(1);
            end
         end
      end

      if (source_end) begin
         // flush whatever is still open, then mark the last token
         if (nxt.mode != MODE_NONE && res_count != 2'd2) begin
            res[res_count[0]] = '{mode_kind(nxt.mode), 32'(nxt.start), 32'(nxt.length),
                                  nxt.mode == MODE_STRING, 1'b0};
            res_count         = res_count + 2'd1;
         end
         if (res_count != 2'd0) begin
            res[1'(res_count - 2'd1)].final_token = 1'b1;
         end
         nxt = '{MODE_NONE, '0, '0, '0};
      end
   end

endmodule

### sv/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Small token queue: takes up to two tokens per cycle, hands out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module stt_queue
   import stt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [1:0]      push_count,
   input  stt_result_type  push_data [2],
   output logic            space_two,
   output logic            out_valid,
   input  logic            out_ready,
   output stt_result_type  out_data
);

   stt_result_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   pop;
   logic [QPTR_BITS-1:0]   wr_next;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign space_two = (count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));
   assign wr_next   = QPTR_BITS'(wr_ptr_ff + QPTR_BITS'(1));

   always_comb begin
      wr_ptr_in = QPTR_BITS'(wr_ptr_ff + QPTR_BITS'(push_count));
      rd_ptr_in = pop ? QPTR_BITS'(rd_ptr_ff + QPTR_BITS'(1)) : rd_ptr_ff;
      count_in  = QCNT_BITS'(count_ff + QCNT_BITS'(push_count) - QCNT_BITS'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data[0];
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_next] <= push_data[1];
      end
   end

endmodule

### sv/source_text_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Streaming lexer: source bytes in, tokens (kind, start, length) out.
// ----------------------------------------------------------------------------
// Tokens are registered in the token queue as their completing byte is accepted.
// Throughput: one byte per cycle while req_tready is high; a byte may yield two
// tokens, which drain one per cycle while rsp_tready is high, from a four-entry
// token queue; req_tready drops when fewer than two queue slots are free.
// Reset: synchronous, clears the pending token, byte offset and queue.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit
   import stt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] char_byte
   input  logic         req_tlast,   // source_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,   // [4:0] token_kind, [36:5] token_start,
                                     // [68:37] token_length, [71:69] zero
   output logic         rsp_tuser,   // open_string
   output logic         rsp_tlast    // final_token
);

   stt_state_type   state_ff, state_in;
   stt_state_type   step_nxt;
   stt_result_type  step_res [2];
   logic [1:0]      step_count;
   logic [1:0]      push_count;
   logic            accept;
   stt_result_type  head;

   assign accept     = req_tvalid && req_tready;
   assign push_count = accept ? step_count : 2'd0;
   assign state_in   = accept ? step_nxt : state_ff;

   stt_step u_step (
      .cur        (state_ff),
      .char_byte  (req_tdata),
      .source_end (req_tlast),
      .nxt        (step_nxt),
      .res        (step_res),
      .res_count  (step_count)
   );

   stt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data  (step_res),
      .space_two  (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{MODE_NONE, '0, '0, '0};
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_tdata = {3'b000, head.length, head.start, head.kind};
   assign rsp_tuser = head.open_string;
   assign rsp_tlast = head.final_token;

endmodule

### tb/source_text_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit_tb
// Feeds source bytes through the tokenizer and checks every token it emits
// against a cycle-free token predictor. A short directed set of sources
// comes first. Random sources built from plausible tokens with some noise
// follow. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit_tb
   import stt_pkg::*;
();

   localparam int RANDOM_BYTES = 750;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 20;

   // one-byte tokens; the kind is the index
   localparam logic [7:0] PUNCT [21] = '{
      "+", "-", "*", "=", "&", "/", "!", "%", "^", "(", ")",
      "[", "]", "{", "}", "<", ">", "\n", ";", ",", "'"
   };

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } src_byte_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;   // [7:0] char_byte
   logic         req_tlast = 1'b0;    // source_end
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;           // [4:0] kind, [36:5] start, [68:37] length,
                                      // [71:69] zero
   logic         rsp_tuser;           // open_string
   logic         rsp_tlast;           // final_token

   src_byte_type   source_bytes[$];
   stt_result_type expected_tokens[$];

   // predictor state
   stt_mode_type run_mode   = MODE_NONE;
   logic [31:0]  run_start  = '0;
   logic [31:0]  run_length = '0;
   logic [31:0]  byte_offset = '0;

   int total_bytes    = 0;
   int bytes_sent     = 0;
   int tokens_checked = 0;
   int sources_made   = 0;
   int error_count    = 0;
   int cycle_count    = 0;

   source_text_tokenizer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // character classes
   // ------------------------------------------------------------------
   function automatic int punct_kind(input logic [7:0] c);
      int k;
      k = -1;
      for (int i = 0; i < 21; i++) begin
         if (PUNCT[i] == c) begin
            k = i;
         end
      end
      return k;
   endfunction

   function automatic bit letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit unknown_char(input logic [7:0] c);
      return punct_kind(c) < 0 && c != CHAR_QUOTE && c != CHAR_SPACE &&
             c != CHAR_TAB && !letter(c) && !digit(c);
   endfunction

   function automatic bit run_continues(input stt_mode_type m, input logic [7:0] c);
      bit r;
      case (m)
         MODE_STRING: r = 1'b1;
         MODE_SPACES: r = (c == CHAR_SPACE);
         MODE_TABS:   r = (c == CHAR_TAB);
         MODE_WORD:   r = letter(c);
         MODE_NUMBER: r = digit(c);
         MODE_ZERO:   r = digit(c) || c == CHAR_X || c == CHAR_B;
         default:     r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] run_token_kind(input stt_mode_type m);
      logic [4:0] k;
      case (m)
         MODE_STRING: k = KIND_STRING;
         MODE_SPACES: k = KIND_SPACES;
         MODE_TABS:   k = KIND_TABS;
         MODE_WORD:   k = KIND_WORD;
         default:     k = KIND_NUMBER;
      endcase
      return k;
   endfunction

   function automatic stt_result_type make_token(input logic [4:0] kind,
         input logic [31:0] start, input logic [31:0] length, input logic open);
      stt_result_type t;
      t.kind        = kind;
      t.start       = start;
      t.length      = length;
      t.open_string = open;
      t.final_token = 1'b0;
      return t;
   endfunction

   // ------------------------------------------------------------------
   // token predictor: one source byte in, up to two tokens queued
   // ------------------------------------------------------------------
   task automatic tokenize_byte(input logic [7:0] c, input logic last);
      stt_result_type tok[2];
      int             n;
      int             pk;
      logic [31:0]    pos;
      stt_mode_type   m;
      n   = 0;
      pos = byte_offset;
      if (run_mode != MODE_NONE && run_continues(run_mode, c)) begin
         if (run_length != '1) run_length = run_length + 1;
         if (run_mode == MODE_ZERO) run_mode = MODE_NUMBER;
         if (run_mode == MODE_STRING && c == CHAR_QUOTE) begin
            tok[n] = make_token(KIND_STRING, run_start, run_length, 1'b0);
            n++;
            run_mode = MODE_NONE;
         end
      end else begin
         if (run_mode != MODE_NONE) begin
            tok[n] = make_token(run_token_kind(run_mode), run_start, run_length, 1'b0);
            n++;
            run_mode = MODE_NONE;
         end
         pk = punct_kind(c);
         if (pk >= 0) begin
            tok[n] = make_token(5'(pk), pos, 32'd1, 1'b0);
            n++;
         end else begin
            m = MODE_NONE;
            if (c == CHAR_QUOTE)      m = MODE_STRING;
            else if (c == CHAR_SPACE) m = MODE_SPACES;
            else if (c == CHAR_TAB)   m = MODE_TABS;
            else if (letter(c))       m = MODE_WORD;
            else if (c == CHAR_ZERO)  m = MODE_ZERO;
            else if (digit(c))        m = MODE_NUMBER;
            if (m != MODE_NONE) begin
               run_mode   = m;
               run_start  = pos;
               run_length = 32'd1;
            end
         end
      end
      byte_offset = pos + 1;
      if (last) begin
         // flush whatever is still open; a string here is unterminated
         if (run_mode != MODE_NONE && n < 2) begin
            tok[n] = make_token(run_token_kind(run_mode), run_start, run_length,
                                run_mode == MODE_STRING);
            n++;
         end
         if (n > 0) tok[n-1].final_token = 1'b1;
         run_mode    = MODE_NONE;
         run_start   = '0;
         run_length  = '0;
         byte_offset = '0;
      end
      for (int i = 0; i < n; i++) expected_tokens.insert(expected_tokens.size(), tok[i]);
   endtask

   // ------------------------------------------------------------------
   // stimulus builders
   // ------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] c, input logic last);
      src_byte_type b;
      b.ch   = c;
      b.last = last;
      source_bytes.insert(source_bytes.size(), b);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
      sources_made++;
   endtask

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(0, 51);
      return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
   endfunction

   function automatic logic [7:0] rand_digit(input int lo);
      return 8'(CHAR_ZERO + $urandom_range(lo, 9));
   endfunction

   function automatic logic [7:0] rand_unknown();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (!unknown_char(c)) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   // one source of mostly well-formed tokens, tlast on its final byte
   task automatic build_source();
      logic [7:0] text[$];
      logic [7:0] c;
      int         ntok;
      int         cls;
      ntok = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(1, 12);
      for (int t = 0; t < ntok; t++) begin
         cls = $urandom_range(0, 99);
         if (cls < 25) begin
            text.insert(text.size(), PUNCT[$urandom_range(0, 20)]);
         end else if (cls < 40) begin
            repeat ($urandom_range(1, 8)) text.insert(text.size(), rand_letter());
         end else if (cls < 55) begin
            text.insert(text.size(), rand_digit(1));
            repeat ($urandom_range(0, 5)) text.insert(text.size(), rand_digit(0));
         end else if (cls < 65) begin
            text.insert(text.size(), CHAR_ZERO);
            case ($urandom_range(0, 3))
               0: text.insert(text.size(), CHAR_X);
               1: text.insert(text.size(), CHAR_B);
               2: text.insert(text.size(), rand_digit(0));
               default: ;
            endcase
            repeat ($urandom_range(0, 4)) text.insert(text.size(), rand_digit(0));
         end else if (cls < 73) begin
            repeat ($urandom_range(1, 5)) text.insert(text.size(), CHAR_SPACE);
         end else if (cls < 80) begin
            repeat ($urandom_range(1, 5)) text.insert(text.size(), CHAR_TAB);
         end else if (cls < 88) begin
            text.insert(text.size(), CHAR_QUOTE);
            repeat ($urandom_range(0, 6)) begin
               c = 8'($urandom_range(0, 255));
               text.insert(text.size(), c == CHAR_QUOTE ? 8'h61 : c);
            end
            // leave the last string of a source open now and then
            if (t != ntok - 1 || $urandom_range(0, 1) == 0)
               text.insert(text.size(), CHAR_QUOTE);
         end else if (cls < 92) begin
            text.insert(text.size(), rand_unknown());
         end else begin
            repeat ($urandom_range(1, 3))
               text.insert(text.size(), 8'($urandom_range(0, 255)));
         end
      end
      for (int i = 0; i < text.size(); i++) push_byte(text[i], i == text.size() - 1);
      sources_made++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------
   // driver
   // ------------------------------------------------------------------
   int req_gap  = 0;
   bit req_calm = 1'b0;

   always @(posedge clock) begin
      src_byte_type b;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            tokenize_byte(req_tdata, req_tlast);
            bytes_sent++;
         end
         if ($urandom_range(0, 63) == 0) req_calm = ~req_calm;
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (source_bytes.size() > 0) begin
               b = source_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= b.ch;
               req_tlast  <= b.last;
               req_gap = req_calm ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor
   // ------------------------------------------------------------------
   int rsp_stall = 0;
   bit rsp_calm  = 1'b0;

   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: token %0d %s mismatch: expected %0h, actual %0h",
                  $time, tokens_checked, what, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      stt_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               $display("%0t: unexpected token: expected none, actual kind %0d start %0h len %0h",
                        $time, rsp_tdata[4:0], rsp_tdata[36:5], rsp_tdata[68:37]);
               error_count++;
            end else begin
               want = expected_tokens.pop_front();
               compare_field("kind", 32'(want.kind), 32'(rsp_tdata[4:0]));
               compare_field("start", want.start, rsp_tdata[36:5]);
               compare_field("length", want.length, rsp_tdata[68:37]);
               compare_field("padding", 32'd0, 32'(rsp_tdata[71:69]));
               compare_field("open_string", 32'(want.open_string), 32'(rsp_tuser));
               compare_field("final_token", 32'(want.final_token), 32'(rsp_tlast));
            end
            tokens_checked++;
         end
         if ($urandom_range(0, 63) == 0) rsp_calm = ~rsp_calm;
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!rsp_calm && $urandom_range(0, 3) == 0) rsp_stall = pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d of %0d bytes sent, %0d tokens outstanding",
                  $time, bytes_sent, total_bytes, expected_tokens.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      // word, space run, hex number closed by a one-byte token at source end
      push_text("Az  0x9;");
      // bare binary prefix, word, tabs, string left open at source end
      push_text("0bZ\t\"");
      // closed string, then an unknown last byte with nothing pending
      push_text("\"x\"~");
      // number split by an unknown byte, pending number flushed at end
      push_byte("9", 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte("5", 1'b1);
      sources_made++;
      // lone one-byte source
      push_text("=");
      // prefix followed by a letter starts a word
      push_text("0xx");
      while (source_bytes.size() < 24 + RANDOM_BYTES) build_source();
      total_bytes = source_bytes.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (bytes_sent < total_bytes || expected_tokens.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d sources, checked %0d tokens, %0d errors",
               bytes_sent, sources_made, tokens_checked, error_count);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### files.f
sv/stt_pkg.sv
sv/stt_step.sv
sv/stt_queue.sv
sv/source_text_tokenizer_unit.sv
tb/source_text_tokenizer_unit_tb.sv
